// ===== rtl/y2p_pkg.sv =====
// ----------------------------------------------------------------------------
// y2p_pkg
// Shared widths, register indexes and transaction types for the YUY2 to
// planar 4:2:0 writer.
// ----------------------------------------------------------------------------
package y2p_pkg;

  localparam int OFFSET_W   = 25;
  localparam int BYTE_W     = 8;
  localparam int CFG_DIM_W  = 12;
  localparam int CFG_DATA_W = 12;
  localparam int CFG_IDX_W  = 2;

  localparam int DEF_MAX_HALF_WIDTH  = 2048;
  localparam int DEF_MAX_HALF_HEIGHT = 2048;

  localparam logic [CFG_DIM_W-1:0] RESET_HALF_WIDTH  = 12'd320;
  localparam logic [CFG_DIM_W-1:0] RESET_HALF_HEIGHT = 12'd240;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_HALF_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HALF_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PLANE_ORDER = 2'd2;

  // plane order codes
  localparam logic PLANE_I420 = 1'b0;
  localparam logic PLANE_YV12 = 1'b1;

  // write slots per macropixel
  localparam int WRITE_SLOTS = 4;
  localparam int SLOT_W      = 2;
  localparam logic [SLOT_W-1:0] LAST_SLOT_EVEN = 2'd3;
  localparam logic [SLOT_W-1:0] LAST_SLOT_ODD  = 2'd1;

  typedef logic [OFFSET_W-1:0] offset_t;
  typedef logic [BYTE_W-1:0]   byte_t;

  // frame geometry derived from the registers
  typedef struct packed {
    offset_t luma_size;    // first chroma plane base
    offset_t second_base;  // second chroma plane base
    logic    plane_order;
  } geom_t;

  // position of the macropixel about to be taken
  typedef struct packed {
    offset_t luma_addr;
    offset_t chroma_off;
    logic    even_row;
    logic    frame_last;
  } pos_t;

endpackage

// ===== rtl/y2p_cfg.sv =====
// ----------------------------------------------------------------------------
// y2p_cfg
// Configuration registers, dimension clamping and registered plane bases.
// ----------------------------------------------------------------------------
module y2p_cfg #(
  parameter int MAX_HALF_WIDTH  = y2p_pkg::DEF_MAX_HALF_WIDTH,
  parameter int MAX_HALF_HEIGHT = y2p_pkg::DEF_MAX_HALF_HEIGHT,
  parameter int HW_W = $clog2(MAX_HALF_WIDTH + 1),
  parameter int HH_W = $clog2(MAX_HALF_HEIGHT + 1)
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [y2p_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [y2p_pkg::CFG_DATA_W-1:0] cfg_data,
  output y2p_pkg::geom_t                 geom,
  output logic [HW_W-1:0]                half_width,
  output logic [HH_W-1:0]                half_height,
  output logic                           restart,
  output logic                           busy
);
  import y2p_pkg::*;

  localparam int PROD_W = HW_W + HH_W;

  logic [CFG_DIM_W-1:0] half_width_r, half_height_r;
  logic                 plane_order_r;
  logic                 busy_r;
  logic [HW_W-1:0]      hw_clamp, hw_r;
  logic [HH_W-1:0]      hh_clamp, hh_r;
  logic [PROD_W-1:0]    prod;
  offset_t              quarter, luma_size;
  geom_t                geom_r, geom_nxt;

  // any write to a known register restarts the frame
  always_comb begin
    case (cfg_index)
      REG_HALF_WIDTH, REG_HALF_HEIGHT, REG_PLANE_ORDER: restart = cfg_we;
      default:                                          restart = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_width_r  <= RESET_HALF_WIDTH;
      half_height_r <= RESET_HALF_HEIGHT;
      plane_order_r <= PLANE_I420;
      busy_r        <= 1'b1;
    end else begin
      busy_r <= restart;
      if (cfg_we) begin
        case (cfg_index)
          REG_HALF_WIDTH:  half_width_r  <= cfg_data[CFG_DIM_W-1:0];
          REG_HALF_HEIGHT: half_height_r <= cfg_data[CFG_DIM_W-1:0];
          REG_PLANE_ORDER: plane_order_r <= cfg_data[0];
          default: ;
        endcase
      end
    end
  end

  // zero acts as one, oversize acts as the maximum
  always_comb begin
    if (half_width_r == '0)
      hw_clamp = HW_W'(1);
    else if (32'(half_width_r) > 32'(MAX_HALF_WIDTH))
      hw_clamp = HW_W'(MAX_HALF_WIDTH);
    else
      hw_clamp = HW_W'(half_width_r);

    if (half_height_r == '0)
      hh_clamp = HH_W'(1);
    else if (32'(half_height_r) > 32'(MAX_HALF_HEIGHT))
      hh_clamp = HH_W'(MAX_HALF_HEIGHT);
    else
      hh_clamp = HH_W'(half_height_r);
  end

  assign prod      = PROD_W'(hw_clamp) * PROD_W'(hh_clamp);
  assign quarter   = OFFSET_W'(prod);
  assign luma_size = quarter << 2;

  always_comb begin
    geom_nxt.luma_size   = luma_size;
    geom_nxt.second_base = luma_size + quarter;
    geom_nxt.plane_order = plane_order_r;
  end

  always_ff @(posedge clk) begin
    geom_r <= geom_nxt;
    hw_r   <= hw_clamp;
    hh_r   <= hh_clamp;
  end

  assign geom        = geom_r;
  assign half_width  = hw_r;
  assign half_height = hh_r;
  assign busy        = busy_r;

endmodule

// ===== rtl/y2p_pos.sv =====
// ----------------------------------------------------------------------------
// y2p_pos
// Column, row, luma address and chroma index tracking.
// ----------------------------------------------------------------------------
module y2p_pos #(
  parameter int MAX_HALF_WIDTH  = y2p_pkg::DEF_MAX_HALF_WIDTH,
  parameter int MAX_HALF_HEIGHT = y2p_pkg::DEF_MAX_HALF_HEIGHT,
  parameter int HW_W = $clog2(MAX_HALF_WIDTH + 1),
  parameter int HH_W = $clog2(MAX_HALF_HEIGHT + 1)
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            restart,
  input  logic            advance,
  input  logic [HW_W-1:0] half_width,
  input  logic [HH_W-1:0] half_height,
  output y2p_pkg::pos_t   pos
);
  import y2p_pkg::*;

  localparam int RW_W  = $clog2(2 * MAX_HALF_HEIGHT);
  localparam int CI_W  = $clog2(MAX_HALF_WIDTH * MAX_HALF_HEIGHT + 1);
  localparam int CC_W  = HW_W + 1;
  localparam int RC_W  = HH_W + 2;

  logic [HW_W-1:0] col_r, col_nxt;
  logic [RW_W-1:0] row_r, row_nxt;
  offset_t         luma_r, luma_nxt;
  logic [CI_W-1:0] chroma_r, chroma_nxt;
  logic            last_col, last_row, even_row;

  assign last_col = (CC_W'(col_r) + CC_W'(1)) >= CC_W'(half_width);
  assign last_row = (RC_W'(row_r) + RC_W'(1)) >= (RC_W'(half_height) << 1);
  assign even_row = ~row_r[0];

  always_comb begin
    col_nxt    = col_r;
    row_nxt    = row_r;
    luma_nxt   = luma_r;
    chroma_nxt = chroma_r;
    if (restart || (advance && last_col && last_row)) begin
      col_nxt    = '0;
      row_nxt    = '0;
      luma_nxt   = '0;
      chroma_nxt = '0;
    end else if (advance) begin
      luma_nxt   = luma_r + OFFSET_W'(2);
      chroma_nxt = chroma_r + CI_W'(even_row);
      if (last_col) begin
        col_nxt = '0;
        row_nxt = row_r + RW_W'(1);
      end else begin
        col_nxt = col_r + HW_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r    <= '0;
      row_r    <= '0;
      luma_r   <= '0;
      chroma_r <= '0;
    end else begin
      col_r    <= col_nxt;
      row_r    <= row_nxt;
      luma_r   <= luma_nxt;
      chroma_r <= chroma_nxt;
    end
  end

  always_comb begin
    pos.luma_addr  = luma_r;
    pos.chroma_off = OFFSET_W'(chroma_r);
    pos.even_row   = even_row;
    pos.frame_last = last_col & last_row;
  end

endmodule

// ===== rtl/y2p_wrq.sv =====
// ----------------------------------------------------------------------------
// y2p_wrq
// Builds the byte writes of one macropixel into a four-slot buffer and
// drains it one write per output transaction.
// ----------------------------------------------------------------------------
module y2p_wrq (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         block,
  input  y2p_pkg::geom_t               geom,
  input  y2p_pkg::pos_t                pos,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [y2p_pkg::BYTE_W-1:0]   in_luma_first,
  input  logic [y2p_pkg::BYTE_W-1:0]   in_chroma_blue,
  input  logic [y2p_pkg::BYTE_W-1:0]   in_luma_second,
  input  logic [y2p_pkg::BYTE_W-1:0]   in_chroma_red,
  output logic                         load,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [y2p_pkg::OFFSET_W-1:0] out_byte_offset,
  output logic [y2p_pkg::BYTE_W-1:0]   out_byte_value,
  output logic                         out_run_end,
  output logic                         out_frame_end
);
  import y2p_pkg::*;

  logic              buf_valid_r, buf_valid_nxt;
  logic [SLOT_W-1:0] ptr_r, ptr_nxt;
  logic [SLOT_W-1:0] last_r;
  logic              frame_last_r;
  offset_t           off_r [WRITE_SLOTS];
  byte_t             val_r [WRITE_SLOTS];
  offset_t           off_nxt [WRITE_SLOTS];
  byte_t             val_nxt [WRITE_SLOTS];
  logic              take, drain_last, room;
  byte_t             first_c, second_c;

  assign take       = buf_valid_r & ~out_stall;
  assign drain_last = take & (ptr_r == last_r);
  assign room       = ~buf_valid_r | drain_last;
  assign in_stall   = block | ~room;
  assign load       = in_valid & ~in_stall;

  assign first_c  = (geom.plane_order == PLANE_YV12) ? in_chroma_red : in_chroma_blue;
  assign second_c = (geom.plane_order == PLANE_YV12) ? in_chroma_blue : in_chroma_red;

  // even row: Y0, first chroma, Y1, second chroma; odd row: Y0, Y1
  always_comb begin
    off_nxt[0] = pos.luma_addr;
    val_nxt[0] = in_luma_first;
    off_nxt[2] = pos.luma_addr + OFFSET_W'(1);
    val_nxt[2] = in_luma_second;
    off_nxt[3] = geom.second_base + pos.chroma_off;
    val_nxt[3] = second_c;
    if (pos.even_row) begin
      off_nxt[1] = geom.luma_size + pos.chroma_off;
      val_nxt[1] = first_c;
    end else begin
      off_nxt[1] = pos.luma_addr + OFFSET_W'(1);
      val_nxt[1] = in_luma_second;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      for (int i = 0; i < WRITE_SLOTS; i++) begin
        off_r[i] <= off_nxt[i];
        val_r[i] <= val_nxt[i];
      end
      last_r       <= pos.even_row ? LAST_SLOT_EVEN : LAST_SLOT_ODD;
      frame_last_r <= pos.frame_last;
    end
  end

  always_comb begin
    buf_valid_nxt = buf_valid_r;
    ptr_nxt       = ptr_r;
    if (load) begin
      buf_valid_nxt = 1'b1;
      ptr_nxt       = '0;
    end else if (drain_last) begin
      buf_valid_nxt = 1'b0;
    end else if (take) begin
      ptr_nxt = ptr_r + SLOT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buf_valid_r <= 1'b0;
      ptr_r       <= '0;
    end else begin
      buf_valid_r <= buf_valid_nxt;
      ptr_r       <= ptr_nxt;
    end
  end

  assign out_valid       = buf_valid_r;
  assign out_byte_offset = off_r[ptr_r];
  assign out_byte_value  = val_r[ptr_r];
  assign out_run_end     = (ptr_r == last_r);
  assign out_frame_end   = out_run_end & frame_last_r;

`ifndef ASSERT_OFF
  a_ptr_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    buf_valid_r |-> (ptr_r <= last_r))
    else $error("write pointer past end of run");

  a_ptr_step: assert property (@(posedge clk) disable iff (!rst_n)
    (take && !drain_last) |=> (buf_valid_r && ptr_r == $past(ptr_r) + SLOT_W'(1)))
    else $error("write pointer did not advance by one");

  a_drain_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (drain_last && !load) |=> !buf_valid_r)
    else $error("buffer still valid after last write");

  a_frame_on_run: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_frame_end) |-> (out_run_end && last_r != '0))
    else $error("frame end outside run end");
`endif

endmodule

// ===== rtl/yuy2_to_planar_420_unit.sv =====
// ----------------------------------------------------------------------------
// yuy2_to_planar_420_unit - YUY2 macropixel to planar 4:2:0 byte writer.
// The first write of a transaction is offered the cycle after accept.
// The single-write output port draining the four-slot write buffer sets the
// pace: four writes per macropixel on even rows, two on odd rows.
// Reset: registers 320/240/I420, position zero; input held after reset and
// after each register write while plane bases are registered.
// ----------------------------------------------------------------------------
module yuy2_to_planar_420_unit #(
  parameter int MAX_HALF_WIDTH  = y2p_pkg::DEF_MAX_HALF_WIDTH,
  parameter int MAX_HALF_HEIGHT = y2p_pkg::DEF_MAX_HALF_HEIGHT
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // input channel: one YUY2 macropixel per transaction
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [y2p_pkg::BYTE_W-1:0]     in_luma_first,
  input  logic [y2p_pkg::BYTE_W-1:0]     in_chroma_blue,
  input  logic [y2p_pkg::BYTE_W-1:0]     in_luma_second,
  input  logic [y2p_pkg::BYTE_W-1:0]     in_chroma_red,
  // result channel: one byte write per transaction
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [y2p_pkg::OFFSET_W-1:0]   out_byte_offset,
  output logic [y2p_pkg::BYTE_W-1:0]     out_byte_value,
  output logic                           out_run_end,
  output logic                           out_frame_end,
  // configuration write port
  input  logic                           cfg_we,
  input  logic [y2p_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [y2p_pkg::CFG_DATA_W-1:0] cfg_data
);
  import y2p_pkg::*;

  // clamped dimension widths
  localparam int HW_W = $clog2(MAX_HALF_WIDTH + 1);
  localparam int HH_W = $clog2(MAX_HALF_HEIGHT + 1);

  geom_t           geom;
  pos_t            pos;
  logic [HW_W-1:0] half_width;
  logic [HH_W-1:0] half_height;
  logic            restart;
  logic            busy;
  logic            load;

  // Register file. The plane bases come from a registered multiply of the
  // clamped dimensions, so busy covers the cycle in which they settle.
  y2p_cfg #(
    .MAX_HALF_WIDTH  (MAX_HALF_WIDTH),
    .MAX_HALF_HEIGHT (MAX_HALF_HEIGHT),
    .HW_W            (HW_W),
    .HH_W            (HH_W)
  ) u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .geom        (geom),
    .half_width  (half_width),
    .half_height (half_height),
    .restart     (restart),
    .busy        (busy)
  );

  // Frame position. Advances once per accepted macropixel and wraps to the
  // frame start after the last one, or on any known register write.
  y2p_pos #(
    .MAX_HALF_WIDTH  (MAX_HALF_WIDTH),
    .MAX_HALF_HEIGHT (MAX_HALF_HEIGHT),
    .HW_W            (HW_W),
    .HH_W            (HH_W)
  ) u_pos (
    .clk         (clk),
    .rst_n       (rst_n),
    .restart     (restart),
    .advance     (load),
    .half_width  (half_width),
    .half_height (half_height),
    .pos         (pos)
  );

  // Write buffer. All offsets of a macropixel are formed at accept time;
  // the next macropixel is taken in the cycle its predecessor's last write
  // leaves, so the output port never idles behind a waiting input while busy is low.
  y2p_wrq u_wrq (
    .clk             (clk),
    .rst_n           (rst_n),
    .block           (busy),
    .geom            (geom),
    .pos             (pos),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_luma_first   (in_luma_first),
    .in_chroma_blue  (in_chroma_blue),
    .in_luma_second  (in_luma_second),
    .in_chroma_red   (in_chroma_red),
    .load            (load),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_byte_offset (out_byte_offset),
    .out_byte_value  (out_byte_value),
    .out_run_end     (out_run_end),
    .out_frame_end   (out_frame_end)
  );

endmodule
